// File: rtl/rfrc_pkg.sv
// Shared types, constants and the byte-wise CRC function for the RTU frame checker.
`default_nettype none

package rfrc_pkg;

  localparam int MaxFrame = 256;
  localparam int CntW     = $clog2(MaxFrame + 1);

  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [7:0]  AddrMax   = 8'hF7;
  localparam logic [7:0]  AddrBcast = 8'h00;
  localparam logic [7:0]  DevAddrRst = 8'h01;

  typedef enum logic [1:0] {
    OpByte    = 2'd0,
    OpGapByte = 2'd1,
    OpLineErr = 2'd2,
    OpSilence = 2'd3
  } rfrc_op_e;

  typedef enum logic [2:0] {
    StOkOwn     = 3'd0,
    StOkBcast   = 3'd1,
    StCrcErr    = 3'd2,
    StNotAddr   = 3'd3,
    StTooShort  = 3'd4,
    StOverflow  = 3'd5
  } rfrc_status_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data;
  } rfrc_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [CntW-1:0] frame_length;
    logic [7:0]      address;
  } rfrc_out_t;

  // Per-beat control from the frame checker to the result register
  typedef struct packed {
    logic      valid;
    rfrc_out_t res;
  } rfrc_res_t;

  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (a[0]) begin
        a = (a >> 1) ^ CrcPoly;
      end else begin
        a = a >> 1;
      end
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rfrc_in_stage.sv
// Input register for event beats.
`default_nettype none

module rfrc_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rfrc_pkg::rfrc_in_t in_data_i,
  input  wire logic              take_i,
  output logic                   vld_o,
  output rfrc_pkg::rfrc_in_t     item_o
);

  logic               vld_q, vld_d;
  rfrc_pkg::rfrc_in_t item_q;
  logic               load;

  assign in_ready_o = !vld_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

// File: rtl/rfrc_frame.sv
// Frame state, CRC accumulation and end-of-frame classification.
`default_nettype none

module rfrc_frame (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  input  wire logic               fire_i,
  input  wire rfrc_pkg::rfrc_in_t item_i,
  output rfrc_pkg::rfrc_res_t     res_o
);

  logic                      armed_q, armed_d;
  logic                      rcv_q, rcv_d;
  logic                      ovf_q, ovf_d;
  logic [rfrc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [15:0]               crc_q, crc_d;
  logic [7:0]                lt0_q, lt0_d;
  logic [7:0]                lt1_q, lt1_d;
  logic [7:0]                faddr_q, faddr_d;
  logic [7:0]                dev_q;
  rfrc_pkg::rfrc_status_e    status;
  rfrc_pkg::rfrc_op_e        op;

  assign op = rfrc_pkg::rfrc_op_e'(item_i.operation);

  // Classify the frame in hand: overflow, length, CRC, then address
  always_comb begin
    if (ovf_q) begin
      status = rfrc_pkg::StOverflow;
    end else if (cnt_q < rfrc_pkg::CntW'(3)) begin
      status = rfrc_pkg::StTooShort;
    end else if (crc_q != {lt1_q, lt0_q}) begin
      status = rfrc_pkg::StCrcErr;
    end else if (faddr_q == rfrc_pkg::AddrBcast) begin
      status = rfrc_pkg::StOkBcast;
    end else if (faddr_q <= rfrc_pkg::AddrMax && faddr_q == dev_q) begin
      status = rfrc_pkg::StOkOwn;
    end else begin
      status = rfrc_pkg::StNotAddr;
    end
  end

  always_comb begin
    armed_d = armed_q;
    rcv_d   = rcv_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    lt0_d   = lt0_q;
    lt1_d   = lt1_q;
    faddr_d = faddr_q;
    res_o.valid            = 1'b0;
    res_o.res.status       = status;
    res_o.res.frame_length = cnt_q;
    res_o.res.address      = faddr_q;

    if (fire_i) begin
      case (op)
        rfrc_pkg::OpLineErr: begin
          armed_d = 1'b0;
          rcv_d   = 1'b0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
          crc_d   = rfrc_pkg::CrcInit;
          lt0_d   = '0;
          lt1_d   = '0;
          faddr_d = '0;
        end
        rfrc_pkg::OpSilence: begin
          if (!armed_q || rcv_q) begin
            res_o.valid = armed_q;
            armed_d = 1'b1;
            rcv_d   = 1'b0;
            ovf_d   = 1'b0;
            cnt_d   = '0;
            crc_d   = rfrc_pkg::CrcInit;
            lt0_d   = '0;
            lt1_d   = '0;
            faddr_d = '0;
          end
        end
        default: begin
          if (armed_q) begin
            // Start a fresh frame on first byte or on a gap restart
            if (!rcv_q || (op == rfrc_pkg::OpGapByte && !ovf_q)) begin
              rcv_d   = 1'b1;
              ovf_d   = 1'b0;
              cnt_d   = '0;
              crc_d   = rfrc_pkg::CrcInit;
              lt0_d   = '0;
              lt1_d   = '0;
              faddr_d = '0;
            end
            if (!ovf_d) begin
              if (cnt_d >= rfrc_pkg::CntW'(rfrc_pkg::MaxFrame)) begin
                ovf_d = 1'b1;
              end else begin
                if (cnt_d >= rfrc_pkg::CntW'(2)) begin
                  crc_d = rfrc_pkg::crc16_step(crc_d, lt0_d);
                end
                lt0_d = lt1_d;
                lt1_d = item_i.data;
                if (cnt_d == '0) begin
                  faddr_d = item_i.data;
                end
                cnt_d = cnt_d + rfrc_pkg::CntW'(1);
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      rcv_q   <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      crc_q   <= rfrc_pkg::CrcInit;
      lt0_q   <= '0;
      lt1_q   <= '0;
      faddr_q <= '0;
      dev_q   <= rfrc_pkg::DevAddrRst;
    end else begin
      armed_q <= armed_d;
      rcv_q   <= rcv_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      lt0_q   <= lt0_d;
      lt1_q   <= lt1_d;
      faddr_q <= faddr_d;
      if (cfg_we_i) begin
        dev_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rfrc_out_stage.sv
// Result register towards the output channel.
`default_nettype none

module rfrc_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire rfrc_pkg::rfrc_res_t res_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rfrc_pkg::rfrc_out_t      out_data_o
);

  logic                vld_q, vld_d;
  rfrc_pkg::rfrc_out_t data_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (fire_i && res_i.valid) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_i.valid) begin
      data_q <= res_i.res;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/rtu_frame_receiver_checker_top.sv
// Top level of the RTU frame receiver and CRC checker.
// Path: a silence beat is held in the input register, then its result beat in the result register.
// Throughput: one event beat per cycle; the input register empties whenever the
// result register is free, so ready only drops while a finished result is stalled.
// Reset: asynchronous, active low; the block comes up disarmed with device address 1
// and drops bytes until the first silence.
`default_nettype none

module rtu_frame_receiver_checker_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rfrc_pkg::rfrc_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rfrc_pkg::rfrc_out_t      out_data_o
);

  logic                item_vld;
  rfrc_pkg::rfrc_in_t  item;
  logic                out_free;
  logic                fire;
  rfrc_pkg::rfrc_res_t res;

  // Advance the held beat when the result register can take whatever it yields
  assign fire = item_vld && out_free;

  // Hold one event beat so the checker sees a registered item
  rfrc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .vld_o      (item_vld),
    .item_o     (item)
  );

  // Update frame state, run the CRC over all but the last two bytes,
  // and classify the frame on silence
  rfrc_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_o       (res)
  );

  // Hold the result beat until the consumer takes it
  rfrc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
